// ----- design/seven_segment_two_wire_writer_macros.svh -----
// Assertion macros used by the checker of the two-wire display writer.
`ifndef SEVEN_SEGMENT_TWO_WIRE_WRITER_MACROS_SVH
`define SEVEN_SEGMENT_TWO_WIRE_WRITER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define SSTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define SSTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sstw_pkg.sv -----
// Types, constants and functions shared by the two-wire display writer.
package sstw_pkg;

    localparam int ADDR_W    = 8;
    localparam int SEG_W     = 8;
    localparam int DIGIT_W   = 4;
    localparam int PHASE_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    // Request codes.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_CMD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_CMD  = 1'b1;

    localparam logic [CFG_W-1:0] FIXED_CMD_RESET = 8'h44;
    localparam logic [CFG_W-1:0] DISP_CMD_RESET  = 8'h8F;

    localparam logic [PHASE_W-1:0] PHASE_IDLE  = 7'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 7'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 7'd126;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    // Pin levels driven towards the display.
    typedef struct packed {
        logic clk;
        logic dio;
        logic drive;
    } t_pins;

    localparam t_pins PINS_IDLE = '{clk: 1'b1, dio: 1'b1, drive: 1'b1};

    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ----- design/sstw_step.sv -----
// Pin phase decoder: works out the pin levels after one phase of the write sequence.
module sstw_step
    import sstw_pkg::*;
(
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [CFG_W-1:0]   i_fixed_cmd,
    input  logic [CFG_W-1:0]   i_disp_cmd,
    input  logic [ADDR_W-1:0]  i_addr,
    input  logic [SEG_W-1:0]   i_seg,
    input  t_pins              i_pins,
    output t_pins              o_pins
);

    logic [PHASE_W-1:0] k;
    logic [5:0]         offset;
    logic               two_bytes;
    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic [5:0]         region;
    logic [5:0]         r0;
    logic [5:0]         stop_step;
    logic [4:0]         r;
    logic [7:0]         value;
    logic [2:0]         bit_idx;
    logic [1:0]         sub;

    always_comb begin
        k = i_phase - PHASE_FIRST;

        // Three transfers: 33 phases, 60 phases, 33 phases.
        if (k < 7'd33) begin
            offset    = k[5:0];
            two_bytes = 1'b0;
            byte0     = i_fixed_cmd;
        end else if (k < 7'd93) begin
            offset    = 6'(k - 7'd33);
            two_bytes = 1'b1;
            byte0     = i_addr;
        end else begin
            offset    = 6'(k - 7'd93);
            two_bytes = 1'b0;
            byte0     = i_disp_cmd;
        end
        byte1 = i_seg;

        region    = two_bytes ? 6'd54 : 6'd27;
        r0        = offset - 6'd3;
        stop_step = r0 - region;

        if (r0 >= 6'd27) begin
            r     = 5'(r0 - 6'd27);
            value = byte1;
        end else begin
            r     = r0[4:0];
            value = byte0;
        end

        // Each data bit takes three phases; split the offset into bit and sub-phase.
        bit_idx = 3'd0;
        sub     = r[1:0];
        for (int j = 0; j < 8; j++) begin
            if (r >= 5'(3 * j)) begin
                bit_idx = 3'(j);
                sub     = 2'(r - 5'(3 * j));
            end
        end

        o_pins = i_pins;
        if (offset < 6'd3) begin
            // Start condition.
            case (offset[1:0])
                2'd0: begin
                    o_pins.clk = 1'b1;
                    o_pins.dio = 1'b1;
                end
                2'd1:    o_pins.dio = 1'b0;
                default: o_pins.clk = 1'b0;
            endcase
        end else if (r0 < region) begin
            if (r < 5'd24) begin
                case (sub)
                    2'd0:    o_pins.clk = 1'b0;
                    2'd1:    o_pins.dio = value[bit_idx];
                    default: o_pins.clk = 1'b1;
                endcase
            end else if (r == 5'd24) begin
                // Acknowledge clock: data released, never sampled.
                o_pins.clk   = 1'b0;
                o_pins.drive = 1'b0;
            end else if (r == 5'd25) begin
                o_pins.clk = 1'b1;
            end else begin
                o_pins.clk   = 1'b0;
                o_pins.drive = 1'b1;
            end
        end else begin
            // Stop condition.
            case (stop_step[1:0])
                2'd0: begin
                    o_pins.clk = 1'b0;
                    o_pins.dio = 1'b0;
                end
                2'd1:    o_pins.clk = 1'b1;
                default: o_pins.dio = 1'b1;
            endcase
        end
    end

endmodule

// ----- design/seven_segment_two_wire_writer.sv -----
// Two-wire seven-segment display writer: one transfer in gives one pin-phase result out.
// A transfer is held in an input register, then the state update goes into the result
// register. One item is taken every cycle unless the result side stalls; the rate is
// set by the phase decode and state update between those registers.
// Synchronous active-low reset empties both registers, returns to idle with all pins
// high and driven, and loads the command registers with 0x44 and 0x8F.
module seven_segment_two_wire_writer
    import sstw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [ADDR_W-1:0]    i_grid_address,
    input  logic [DIGIT_W-1:0]   i_digit,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_clk_level,
    output logic                 o_dio_level,
    output logic                 o_dio_drive,
    output logic                 o_busy_res,
    output logic                 o_rejected
);

    logic                 r_in_valid;
    logic                 r_in_req;
    logic [ADDR_W-1:0]    r_in_addr;
    logic [DIGIT_W-1:0]   r_in_digit;

    logic [CFG_W-1:0]     r_fixed_cmd;
    logic [CFG_W-1:0]     r_disp_cmd;
    logic [PHASE_W-1:0]   r_phase;
    logic [ADDR_W-1:0]    r_addr;
    logic [SEG_W-1:0]     r_seg;
    t_pins                r_pins;

    logic                 r_out_valid;
    logic                 r_out_busy;
    logic                 r_out_rej;
    t_pins                r_out_pins;

    logic [PHASE_W-1:0]   n_phase;
    logic [ADDR_W-1:0]    n_addr;
    logic [SEG_W-1:0]     n_seg;
    t_pins                n_pins;
    logic                 n_rej;

    t_pins                step_pins;
    logic                 advance;
    logic                 process;
    logic                 in_take;

    // The result register frees up when it is empty or its transfer completes.
    assign advance    = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    sstw_step u_step (
        .i_phase     (r_phase),
        .i_fixed_cmd (r_fixed_cmd),
        .i_disp_cmd  (r_disp_cmd),
        .i_addr      (r_addr),
        .i_seg       (r_seg),
        .i_pins      (r_pins),
        .o_pins      (step_pins)
    );

    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_seg   = r_seg;
        n_pins  = r_pins;
        n_rej   = 1'b0;
        if (r_in_req == REQ_WRITE) begin
            if (r_phase != PHASE_IDLE) begin
                n_rej = 1'b1;
            end else begin
                n_addr  = r_in_addr;
                n_seg   = seg_code(r_in_digit);
                n_phase = PHASE_FIRST;
            end
        end else if (r_phase != PHASE_IDLE && r_phase <= PHASE_LAST) begin
            n_pins  = step_pins;
            n_phase = (r_phase == PHASE_LAST) ? PHASE_IDLE : r_phase + 7'd1;
        end else begin
            n_phase = PHASE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fixed_cmd <= FIXED_CMD_RESET;
            r_disp_cmd  <= DISP_CMD_RESET;
            r_phase     <= PHASE_IDLE;
            r_addr      <= '0;
            r_seg       <= '0;
            r_pins      <= PINS_IDLE;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (process) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_addr      <= n_addr;
                r_seg       <= n_seg;
                r_pins      <= n_pins;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIXED_CMD: r_fixed_cmd <= i_cfg_data;
                    CFG_DISP_CMD:  r_disp_cmd  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req   <= i_req_type;
            r_in_addr  <= i_grid_address;
            r_in_digit <= i_digit;
        end
        if (process) begin
            r_out_pins <= n_pins;
            r_out_busy <= (n_phase != PHASE_IDLE);
            r_out_rej  <= n_rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_clk_level = r_out_pins.clk;
    assign o_dio_level = r_out_pins.dio;
    assign o_dio_drive = r_out_pins.drive;
    assign o_busy_res  = r_out_busy;
    assign o_rejected  = r_out_rej;

endmodule

// ----- design/sstw_checker.sv -----
// Port-level checker for the two-wire display writer, bound to the top level.
`include "seven_segment_two_wire_writer_macros.svh"

module sstw_checker
    import sstw_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_clk_level,
    input logic                 o_dio_level,
    input logic                 o_dio_drive,
    input logic                 o_busy_res,
    input logic                 o_rejected
);

    // A rejected request never disturbs a sequence that is under way.
    `SSTW_ASSERT_NOW(a_rej_busy, i_clk, i_rst_n, o_out_valid && o_rejected, o_busy_res, "rejected result while not busy")

    // The data pin is only released for an acknowledge clock inside a sequence.
    `SSTW_ASSERT_NOW(a_release_busy, i_clk, i_rst_n, o_out_valid && !o_dio_drive, o_busy_res, "data released outside a sequence")

    // Between sequences both pins rest high and the data pin is driven.
    `SSTW_ASSERT_NOW(a_idle_pins, i_clk, i_rst_n, o_out_valid && !o_busy_res, o_clk_level && o_dio_level && o_dio_drive, "pins not at rest while idle")

    // A stalled result holds until its transfer completes.
    `SSTW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_clk_level) && $stable(o_dio_level) && $stable(o_busy_res), "stalled result changed")

endmodule

bind seven_segment_two_wire_writer sstw_checker u_sstw_checker (.*);

// ----- test/seven_segment_two_wire_writer_tb.sv -----
// Self-checking testbench for the two-wire seven-segment display writer.
module seven_segment_two_wire_writer_tb;
    import sstw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT = 200;
    localparam int SEQ_TICKS   = int'(PHASE_LAST);

    // Segment codes of the digits 0 to 9, digit 0 in the lowest byte.
    localparam logic [79:0] DIGIT_SEGMENTS = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_drive;
        logic busy_res;
        logic rejected;
    } t_pin_result;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_FIXED_CMD;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 i_req_type     = REQ_TICK;
    logic [ADDR_W-1:0]    i_grid_address = '0;
    logic [DIGIT_W-1:0]   i_digit        = '0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_clk_level;
    logic                 o_dio_level;
    logic                 o_dio_drive;
    logic                 o_busy_res;
    logic                 o_rejected;

    // Shadow of the block's state, updated at every accepted transfer.
    logic [PHASE_W-1:0] disp_phase;
    logic [ADDR_W-1:0]  latched_addr;
    logic [SEG_W-1:0]   latched_seg;
    t_pins              bus_pins;
    logic [CFG_W-1:0]   fixed_cmd;
    logic [CFG_W-1:0]   disp_cmd;

    t_pin_result pending_pins[$];
    int          mismatches   = 0;
    int          stuck_cycles = 0;
    int          stall_left   = 0;
    logic        gaps_on      = 1'b1;
    int          ticks_left   = 0;

    seven_segment_two_wire_writer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_grid_address (i_grid_address),
        .i_digit        (i_digit),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_clk_level    (o_clk_level),
        .o_dio_level    (o_dio_level),
        .o_dio_drive    (o_dio_drive),
        .o_busy_res     (o_busy_res),
        .o_rejected     (o_rejected)
    );

    always #5 i_clk = ~i_clk;

    // Pin action for step o of a framed transfer carrying nbytes bytes.
    task automatic frame_step(input int unsigned o, input int unsigned nbytes,
                              input logic [7:0] b0, input logic [7:0] b1);
        int unsigned k;
        int unsigned r;
        logic [7:0]  value;
        if (o < 3) begin
            case (o)
                0: begin
                    bus_pins.clk = 1'b1;
                    bus_pins.dio = 1'b1;
                end
                1: bus_pins.dio = 1'b0;
                default: bus_pins.clk = 1'b0;
            endcase
        end else if (o < 3 + 27 * nbytes) begin
            k     = o - 3;
            r     = k % 27;
            value = (k / 27 == 0) ? b0 : b1;
            if (r < 24) begin
                case (r % 3)
                    0: bus_pins.clk = 1'b0;
                    1: bus_pins.dio = value[r / 3];
                    default: bus_pins.clk = 1'b1;
                endcase
            end else if (r == 24) begin
                // Acknowledge clock: the data pin is released.
                bus_pins.clk   = 1'b0;
                bus_pins.drive = 1'b0;
            end else if (r == 25) begin
                bus_pins.clk = 1'b1;
            end else begin
                bus_pins.clk   = 1'b0;
                bus_pins.drive = 1'b1;
            end
        end else begin
            r = o - 3 - 27 * nbytes;
            case (r)
                0: begin
                    bus_pins.clk = 1'b0;
                    bus_pins.dio = 1'b0;
                end
                1: bus_pins.clk = 1'b1;
                default: bus_pins.dio = 1'b1;
            endcase
        end
    endtask

    task automatic pin_phase_step(input int unsigned p);
        int unsigned k;
        k = p - 1;
        if (k < 33)
            frame_step(k, 1, fixed_cmd, 8'h00);
        else if (k < 93)
            frame_step(k - 33, 2, latched_addr, latched_seg);
        else
            frame_step(k - 93, 1, disp_cmd, 8'h00);
    endtask

    task automatic predict_pins(input logic req, input logic [ADDR_W-1:0] addr,
                                input logic [DIGIT_W-1:0] dig);
        t_pin_result r;
        int          di;
        r.rejected = 1'b0;
        di         = int'(dig);
        if (req == REQ_WRITE) begin
            if (disp_phase != PHASE_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                latched_addr = addr;
                latched_seg  = (di <= 9) ? DIGIT_SEGMENTS[di * 8 +: 8] : SEG_BLANK;
                disp_phase   = PHASE_FIRST;
            end
        end else if (disp_phase != PHASE_IDLE) begin
            pin_phase_step(int'(disp_phase));
            disp_phase = (disp_phase == PHASE_LAST) ? PHASE_IDLE : disp_phase + 1'b1;
        end
        r.clk_level = bus_pins.clk;
        r.dio_level = bus_pins.dio;
        r.dio_drive = bus_pins.drive;
        r.busy_res  = (disp_phase != PHASE_IDLE);
        pending_pins.push_back(r);
    endtask

    function automatic void check_bit(input string name, input logic exp_v,
                                      input logic act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0b, got %0b", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Checks results first, then applies register writes and accepted requests.
    always @(posedge i_clk) begin
        t_pin_result e;
        logic        in_xfer;
        logic        out_xfer;
        in_xfer  = i_rst_n && i_in_valid && !o_in_stall;
        out_xfer = i_rst_n && o_out_valid && !i_out_stall;
        if (!i_rst_n) begin
            disp_phase   = PHASE_IDLE;
            latched_addr = '0;
            latched_seg  = '0;
            bus_pins     = PINS_IDLE;
            fixed_cmd    = FIXED_CMD_RESET;
            disp_cmd     = DISP_CMD_RESET;
        end else begin
            if (out_xfer) begin
                if (pending_pins.size() == 0) begin
                    $error("result transfer with no result expected");
                    mismatches++;
                end else begin
                    e = pending_pins.pop_front();
                    check_bit("clk_level", e.clk_level, o_clk_level);
                    check_bit("dio_level", e.dio_level, o_dio_level);
                    check_bit("dio_drive", e.dio_drive, o_dio_drive);
                    check_bit("busy_res", e.busy_res, o_busy_res);
                    check_bit("rejected", e.rejected, o_rejected);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIXED_CMD: fixed_cmd = i_cfg_data;
                    CFG_DISP_CMD:  disp_cmd  = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer)
                predict_pins(i_req_type, i_grid_address, i_digit);
        end
        stuck_cycles = (in_xfer || out_xfer) ? 0 : stuck_cycles + 1;
    end

    // Result side back-pressure in short random bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("seven_segment_two_wire_writer_tb NOT OK");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_item(input logic req, input logic [ADDR_W-1:0] addr,
                             input logic [DIGIT_W-1:0] dig);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_grid_address <= addr;
        i_digit        <= dig;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (req == REQ_WRITE && ticks_left == 0)
            ticks_left = SEQ_TICKS;
        else if (req == REQ_TICK && ticks_left > 0)
            ticks_left--;
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, ADDR_W'($urandom_range(0, 255)), DIGIT_W'($urandom_range(0, 15)));
    endtask

    task automatic send_random_write();
        send_item(REQ_WRITE, ADDR_W'($urandom_range(0, 255)),
                  DIGIT_W'($urandom_range(0, 15)));
    endtask

    // Ticks the current sequence to its end, with the odd request while busy.
    task automatic finish_sequence(input int unsigned reject_odds);
        while (ticks_left > 0) begin
            if (reject_odds != 0 && $urandom_range(1, reject_odds) == 1)
                send_random_write();
            else
                send_tick();
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_pins.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic test_idle_and_busy_requests();
        send_item(REQ_TICK, 8'hFF, 4'hF);
        send_item(REQ_TICK, 8'h00, 4'h0);
        send_item(REQ_WRITE, 8'hFF, 4'hF);
        send_item(REQ_WRITE, 8'h00, 4'h0);
        repeat (15) send_tick();
        send_item(REQ_WRITE, 8'hC0, 4'h9);
        repeat (3) send_tick();
        send_item(REQ_WRITE, 8'h3C, 4'hA);
        finish_sequence(0);
        send_item(REQ_TICK, 8'hAA, 4'h5);
        send_item(REQ_WRITE, 8'h00, 4'h0);
        finish_sequence(0);
    endtask

    task automatic test_register_extremes();
        logic [CFG_W-1:0] fixed_vals[3];
        logic [CFG_W-1:0] disp_vals[3];
        fixed_vals = '{8'h00, 8'hFF, 8'hA5};
        disp_vals  = '{8'hFF, 8'h00, 8'h5A};
        for (int i = 0; i < 3; i++) begin
            write_register(CFG_FIXED_CMD, fixed_vals[i]);
            write_register(CFG_DISP_CMD, disp_vals[i]);
            send_random_write();
            finish_sequence(20);
        end
    endtask

    // A command register changed part-way through a sequence applies from the next phase.
    task automatic test_register_write_mid_sequence();
        send_item(REQ_WRITE, 8'hC3, 4'h8);
        repeat (12) send_tick();
        write_register(CFG_FIXED_CMD, 8'h3C);
        repeat (90) send_tick();
        write_register(CFG_DISP_CMD, 8'hC3);
        repeat (10) send_tick();
        write_register(CFG_DISP_CMD, 8'h81);
        finish_sequence(0);
    endtask

    task automatic test_random_sequences();
        for (int s = 0; s < 4; s++) begin
            if (s == 0 || $urandom_range(0, 2) == 0) begin
                write_register(CFG_FIXED_CMD, CFG_W'($urandom_range(0, 255)));
                write_register(CFG_DISP_CMD, CFG_W'($urandom_range(0, 255)));
            end
            gaps_on <= (s >= 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            // Noise at idle: the first write among it starts the sequence.
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1) == 0)
                    send_tick();
                else
                    send_random_write();
            end
            if (ticks_left == 0)
                send_random_write();
            finish_sequence(16);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_busy_requests();
        test_register_extremes();
        test_register_write_mid_sequence();
        test_random_sequences();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending_pins.size() == 0)
            $display("seven_segment_two_wire_writer_tb OK");
        else
            $display("seven_segment_two_wire_writer_tb NOT OK");
        $finish;
    end

endmodule
